[design/gcd_pkg.sv]
// Shared types, constants and elaboration-time tables for the great-circle distance block.
`default_nettype none
package gcd_pkg;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int SQRT_BITS = 62;
  localparam int PADDR_W = 3;

  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [31:0] PI_HI = 32'h3243_F6A8;
  localparam logic [31:0] PI_LO = 32'h885A_308D;
  localparam logic [127:0] ONE_Q120 = 128'h0100_0000_0000_0000_0000_0000_0000_0000;
  localparam logic [35:0] DIST_MAX = 36'd52707178000;
  localparam logic [23:0] RADIUS_RESET = 24'd6371000;
  localparam logic [33:0] MM_PER_M = 34'd1000;

  // register index decoded from paddr[2]
  localparam logic REG_RADIUS = 1'b0;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic [63:0]            rem;
    logic [SQRT_BITS-1:0]   root;
    logic [2*SQRT_BITS-1:0] opnd;
  } sqrt_state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] r;
    r = v[63] ? 64'(-v) : 64'(v);
    return r;
  endfunction

  // shift-subtract long division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 by truncated series
  function automatic logic signed [63:0] atan_q60(input int i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] k;
    if (i == 0) return PI_Q60 >> 2;
    p = 64'd1 << (60 - i);
    sum = '0;
    k = '0;
    for (int s = 0; s < 64; s++) begin
      if (p != 64'd0) begin
        term = udiv64(p, (k << 1) + 64'd1);
        if (k[0]) sum = sum - term;
        else sum = sum + term;
        p = (p >> i) >> i;
        k = k + 64'd1;
      end
    end
    return sum;
  endfunction

  // inverse CORDIC gain in Q60 for n stages
  function automatic logic [63:0] gain_q60(input int n);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [63:0] mx;
    logic [63:0] my;
    logic [127:0] s;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] rem;
    logic [63:0] q;
    x = ONE_Q60;
    y = '0;
    z = '0;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q60(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q60(i);
      end
    end
    mx = mag64(x);
    my = mag64(y);
    s = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my};
    r = '0;
    for (int b = 61; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= s) r = cand;
    end
    rem = ONE_Q60;
    q = '0;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= r) begin
        rem = rem - r;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

endpackage
`default_nettype wire

[design/gcd_delay.sv]
// Fixed-depth delay line for sideband bits.
`default_nettype none
module gcd_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);
  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(DEPTH); i++) tap_q[i] <= '0;
    end else begin
      tap_q[0] <= d_i;
      for (int i = 1; i < int'(DEPTH); i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];
endmodule
`default_nettype wire

[design/gcd_mul.sv]
// Two-stage 64x64 unsigned multiplier from four 32x32 partial products.
`default_nettype none
module gcd_mul (
  input  logic         clk_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);
  logic [63:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [127:0] p_q;

  always_ff @(posedge clk_i) begin
    pp00_q <= {32'd0, a_i[31:0]}  * {32'd0, b_i[31:0]};
    pp01_q <= {32'd0, a_i[31:0]}  * {32'd0, b_i[63:32]};
    pp10_q <= {32'd0, a_i[63:32]} * {32'd0, b_i[31:0]};
    pp11_q <= {32'd0, a_i[63:32]} * {32'd0, b_i[63:32]};
    p_q    <= {64'd0, pp00_q} + {32'd0, pp01_q, 32'd0} + {32'd0, pp10_q, 32'd0}
              + {pp11_q, 64'd0};
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

[design/gcd_cordic_cell.sv]
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
`default_nettype none
module gcd_cordic_cell #(
  parameter int IDX    = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                clk_i,
  input  gcd_pkg::cordic_vec_t v_i,
  output gcd_pkg::cordic_vec_t v_o
);
  import gcd_pkg::*;

  localparam logic signed [63:0] Atan = atan_q60(IDX);

  cordic_vec_t v_d, v_q;
  logic signed [63:0] dx, dy;
  logic plus;

  always_comb begin
    dx = v_i.y >>> IDX;
    dy = v_i.x >>> IDX;
    plus = VECTOR ? !v_i.y[63] : v_i.z[63];
    if (plus) begin
      v_d.x = v_i.x + dx;
      v_d.y = v_i.y - dy;
      v_d.z = v_i.z + Atan;
    end else begin
      v_d.x = v_i.x - dx;
      v_d.y = v_i.y + dy;
      v_d.z = v_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;
endmodule
`default_nettype wire

[design/gcd_sqrt_cell.sv]
// One digit of a restoring floor square root, registered.
`default_nettype none
module gcd_sqrt_cell (
  input  logic                clk_i,
  input  gcd_pkg::sqrt_state_t s_i,
  output gcd_pkg::sqrt_state_t s_o
);
  import gcd_pkg::*;

  sqrt_state_t s_d, s_q;
  logic [65:0] t;
  logic [65:0] trial;

  always_comb begin
    t = {s_i.rem, s_i.opnd[2*SQRT_BITS-1 -: 2]};
    trial = {2'b00, s_i.root, 2'b01};
    s_d.opnd = {s_i.opnd[2*SQRT_BITS-3:0], 2'b00};
    if (t >= trial) begin
      s_d.rem  = 64'(t - trial);
      s_d.root = {s_i.root[SQRT_BITS-2:0], 1'b1};
    end else begin
      s_d.rem  = t[63:0];
      s_d.root = {s_i.root[SQRT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign s_o = s_q;
endmodule
`default_nettype wire

[design/great_circle_distance.sv]
// Top level: haversine great-circle distance pipeline with APB radius register.
// Throughput: one point pair per cycle; busy stays low, every beat is taken.
// Depth is set by the four parallel rotation CORDIC chains, the 62-cell square
// root chains and the vectoring CORDIC chain, each one cell per clock.
// Reset clears the valid pipeline and loads the radius with 6371000 m.
`default_nettype none
module great_circle_distance #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          first_latitude_i,
  input  logic signed [31:0]          first_longitude_i,
  input  logic signed [31:0]          second_latitude_i,
  input  logic signed [31:0]          second_longitude_i,
  output logic                        done_o,
  output logic [35:0]                 distance_mm_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import gcd_pkg::*;

  localparam int N = CORDIC_STAGES;
  localparam int Lat = 2 * N + 78;
  localparam logic signed [63:0] GainFix = gain_q60(N);

  // ---------------------------------------------------------------- config
  logic [23:0] radius_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIUS);
  assign prdata = (paddr[2] == REG_RADIUS) ? {8'd0, radius_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_wr) begin
      radius_q <= pwdata[23:0];
    end
  end

  // Pipeline never stalls, so a new pair is always welcome.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- valid
  gcd_delay #(.WIDTH(1), .DEPTH(Lat)) u_valid (
    .clk_i, .rst_ni, .d_i(start), .q_o(done_o)
  );

  // ---------------------------------------------------------------- stage A
  // Wrapped differences and latitude folding into [-90, 90] degrees.
  // Lanes: 0 dlat/2, 1 dlon/2, 2 lat1, 3 lat2.
  logic [31:0] a_m_q [4];
  logic [1:0]  a_neg_q;
  logic [31:0] dlat, dlon;
  logic [31:0] lat1_f, lat2_f;
  logic        neg1, neg2;

  always_comb begin
    dlat = 32'(second_latitude_i - first_latitude_i);
    dlon = 32'(second_longitude_i - first_longitude_i);
    neg1 = (first_latitude_i > 32'sd1073741824) || (first_latitude_i < -32'sd1073741824);
    neg2 = (second_latitude_i > 32'sd1073741824) || (second_latitude_i < -32'sd1073741824);
    // adding or subtracting half a turn is the same as flipping the sign bit
    lat1_f = neg1 ? (first_latitude_i ^ 32'h8000_0000) : first_latitude_i;
    lat2_f = neg2 ? (second_latitude_i ^ 32'h8000_0000) : second_latitude_i;
  end

  always_ff @(posedge clk_i) begin
    a_m_q[0] <= dlat[31] ? 32'(-dlat) : dlat;
    a_m_q[1] <= dlon[31] ? 32'(-dlon) : dlon;
    a_m_q[2] <= lat1_f[31] ? 32'(-lat1_f) : lat1_f;
    a_m_q[3] <= lat2_f[31] ? 32'(-lat2_f) : lat2_f;
    a_neg_q  <= {neg2, neg1};
  end

  // ---------------------------------------------------------------- stage B/C
  // Angle units to Q60 radians: two constant 32x32 products, then shift-add.
  logic [63:0] b_ph_q [4];
  logic [63:0] b_pl_q [4];
  logic signed [63:0] c_z_q [4];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      b_ph_q[k] <= {32'd0, a_m_q[k]} * {32'd0, PI_HI};
      b_pl_q[k] <= {32'd0, a_m_q[k]} * {32'd0, PI_LO};
    end
    for (int k = 0; k < 2; k++) c_z_q[k] <= b_ph_q[k] + (b_pl_q[k] >> 32);
    for (int k = 2; k < 4; k++) c_z_q[k] <= (b_ph_q[k] << 1) + (b_pl_q[k] >> 31);
  end

  // ---------------------------------------------------------------- rotation CORDIC
  cordic_vec_t rot_v [4][N+1];

  for (genvar k = 0; k < 4; k++) begin : g_rot
    assign rot_v[k][0] = '{x: GainFix, y: 64'sd0, z: c_z_q[k]};
    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cordic_cell #(.IDX(i), .VECTOR(1'b0)) u_cell (
        .clk_i, .v_i(rot_v[k][i]), .v_o(rot_v[k][i+1])
      );
    end
  end

  logic [1:0] neg_dly;
  gcd_delay #(.WIDTH(2), .DEPTH(N + 2)) u_neg_dly (
    .clk_i, .rst_ni, .d_i(a_neg_q), .q_o(neg_dly)
  );

  // ---------------------------------------------------------------- stage D
  logic [63:0] d_s1_q, d_s2_q, d_c1_q, d_c2_q;
  logic        d_ndiff_q;

  always_ff @(posedge clk_i) begin
    d_s1_q    <= mag64(rot_v[0][N].y);
    d_s2_q    <= mag64(rot_v[1][N].y);
    d_c1_q    <= mag64(rot_v[2][N].x);
    d_c2_q    <= mag64(rot_v[3][N].x);
    // sign of cos(lat1)*cos(lat2) after folding
    d_ndiff_q <= (neg_dly[0] ^ rot_v[2][N].x[63]) ^ (neg_dly[1] ^ rot_v[3][N].x[63]);
  end

  // ---------------------------------------------------------------- products
  // p = c1*c2 >> 60, u = p*s2 >> 60, term = u*s2, sq = s1*s1
  logic [127:0] m1_p, m2_p, m3_p, m4_p;
  logic [63:0]  s2_d2, s2_d4, s1_d4;
  logic         ndiff_d6;

  gcd_mul u_m1 (.clk_i, .a_i(d_c1_q), .b_i(d_c2_q), .p_o(m1_p));

  gcd_delay #(.WIDTH(64), .DEPTH(2)) u_s2_d2 (
    .clk_i, .rst_ni, .d_i(d_s2_q), .q_o(s2_d2)
  );
  gcd_delay #(.WIDTH(64), .DEPTH(2)) u_s2_d4 (
    .clk_i, .rst_ni, .d_i(s2_d2), .q_o(s2_d4)
  );
  gcd_delay #(.WIDTH(64), .DEPTH(4)) u_s1_d4 (
    .clk_i, .rst_ni, .d_i(d_s1_q), .q_o(s1_d4)
  );
  gcd_delay #(.WIDTH(1), .DEPTH(6)) u_ndiff_d6 (
    .clk_i, .rst_ni, .d_i(d_ndiff_q), .q_o(ndiff_d6)
  );

  gcd_mul u_m2 (.clk_i, .a_i(m1_p[123:60]), .b_i(s2_d2), .p_o(m2_p));
  gcd_mul u_m3 (.clk_i, .a_i(m2_p[123:60]), .b_i(s2_d4), .p_o(m3_p));
  gcd_mul u_m4 (.clk_i, .a_i(s1_d4), .b_i(s1_d4), .p_o(m4_p));

  // ---------------------------------------------------------------- stage E
  // haversine term a, clamped to [0, 1] in Q120; b = 1 - a
  logic [127:0] e_a_q, e_b_q;
  logic [127:0] hav_a, hav_sum;

  always_comb begin
    hav_sum = m4_p + m3_p;
    if (ndiff_d6) begin
      hav_a = (m3_p >= m4_p) ? 128'd0 : (m4_p - m3_p);
    end else begin
      hav_a = (hav_sum > ONE_Q120) ? ONE_Q120 : hav_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    e_a_q <= hav_a;
    e_b_q <= ONE_Q120 - hav_a;
  end

  // ---------------------------------------------------------------- square roots
  // Operands at or above 2^124 give an all-ones root, like a greedy 62-bit search.
  sqrt_state_t sqa [SQRT_BITS+1];
  sqrt_state_t sqb [SQRT_BITS+1];
  logic [1:0]  sat_dly;

  assign sqa[0] = '{rem: 64'd0, root: '0, opnd: e_a_q[2*SQRT_BITS-1:0]};
  assign sqb[0] = '{rem: 64'd0, root: '0, opnd: e_b_q[2*SQRT_BITS-1:0]};

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    gcd_sqrt_cell u_sqa (.clk_i, .s_i(sqa[j]), .s_o(sqa[j+1]));
    gcd_sqrt_cell u_sqb (.clk_i, .s_i(sqb[j]), .s_o(sqb[j+1]));
  end

  gcd_delay #(.WIDTH(2), .DEPTH(SQRT_BITS)) u_sat_dly (
    .clk_i, .rst_ni,
    .d_i({(e_b_q[127:2*SQRT_BITS] != '0), (e_a_q[127:2*SQRT_BITS] != '0)}),
    .q_o(sat_dly)
  );

  logic [SQRT_BITS-1:0] root_a, root_b;
  assign root_a = sat_dly[0] ? '1 : sqa[SQRT_BITS].root;
  assign root_b = sat_dly[1] ? '1 : sqb[SQRT_BITS].root;

  // ---------------------------------------------------------------- vectoring CORDIC
  // atan2(sqrt(a), sqrt(1-a)) accumulates in z
  cordic_vec_t vec_v [N+1];

  assign vec_v[0] = '{x: 64'($unsigned(root_b)), y: 64'($unsigned(root_a)), z: 64'sd0};

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcd_cordic_cell #(.IDX(i), .VECTOR(1'b1)) u_cell (
      .clk_i, .v_i(vec_v[i]), .v_o(vec_v[i+1])
    );
  end

  // ---------------------------------------------------------------- stage F
  logic [63:0] f_c_q;

  always_ff @(posedge clk_i) begin
    f_c_q <= vec_v[N].z[63] ? 64'd0 : {vec_v[N].z[62:0], 1'b0};
  end

  // ---------------------------------------------------------------- scale and round
  logic [33:0]  radius_mm;
  logic [127:0] m5_p;
  logic [96:0]  g_sum_q;
  logic [36:0]  dist_raw;
  logic [35:0]  dist_q;

  assign radius_mm = {10'd0, radius_q} * MM_PER_M;

  gcd_mul u_m5 (.clk_i, .a_i({30'd0, radius_mm}), .b_i(f_c_q), .p_o(m5_p));

  assign dist_raw = g_sum_q[96:60];

  always_ff @(posedge clk_i) begin
    g_sum_q <= m5_p[96:0] + (97'd1 << 59);
    dist_q  <= (dist_raw > {1'b0, DIST_MAX}) ? DIST_MAX : dist_raw[35:0];
  end

  assign distance_mm_o = dist_q;

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (distance_mm_o <= DIST_MAX))
    else $error("distance above saturation limit");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##Lat done_o)
    else $error("accepted beat did not complete on schedule");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (radius_q == $past(pwdata[23:0])))
    else $error("radius register write lost");
`endif

endmodule
`default_nettype wire

[tb/great_circle_distance_test.sv]
// Self-checking testbench for the great-circle distance block: random and edge-case point pairs.
`default_nettype none
module great_circle_distance_test;
  import gcd_pkg::*;

  localparam int STAGES = 32;
  localparam int LATENCY = 2 * STAGES + 78;
  localparam int STALL_LIMIT = 20 * LATENCY;
  localparam logic [PADDR_W-1:0] ADDR_RADIUS = PADDR_W'(0);
  localparam logic [23:0] RADIUS_MAX = 24'hFF_FFFF;
  localparam logic [23:0] RADIUS_MIN = 24'd1;
  localparam logic signed [31:0] LAT_N = 32'sh4000_0000;
  localparam logic signed [31:0] LAT_S = -32'sh4000_0000;
  localparam logic signed [31:0] LON_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] LON_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] lat1;
    logic signed [31:0] lon1;
    logic signed [31:0] lat2;
    logic signed [31:0] lon2;
  } point_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] first_latitude_i = '0;
  logic signed [31:0] first_longitude_i = '0;
  logic signed [31:0] second_latitude_i = '0;
  logic signed [31:0] second_longitude_i = '0;
  logic done_o;
  logic [35:0] distance_mm_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  great_circle_distance #(.CORDIC_STAGES(STAGES)) dut (.*);

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor: haversine distance in Q60 / Q120 fixed point
  // ---------------------------------------------------------------------
  logic signed [63:0] arctan_q60 [STAGES];
  logic signed [63:0] inv_gain_q60;
  logic [23:0] radius_m = RADIUS_RESET;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] mul128(input logic [63:0] a, input logic [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  // floor square root of a Q120 value, 62-bit result
  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    for (int b = 61; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (mul128(cand, cand) <= n) r = cand;
    end
    return r;
  endfunction

  // rotation mode, y starts at zero
  task automatic rotate_vec(input logic signed [63:0] x0, input logic signed [63:0] z0,
                            output logic signed [63:0] xo, output logic signed [63:0] yo);
    logic signed [63:0] x, y, z, dx, dy;
    x = x0;
    y = '0;
    z = z0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_q60[i];
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_q60[i];
      end
    end
    xo = x;
    yo = y;
  endtask

  task automatic build_tables();
    logic [63:0] p, acc, term, k, an, rem, q;
    logic signed [63:0] x, y;
    arctan_q60[0] = PI_Q60 >> 2;
    for (int i = 1; i < STAGES; i++) begin
      p = 64'd1 << (60 - i);
      acc = '0;
      k = '0;
      while (p != 0) begin
        term = p / (2 * k + 1);
        if (k[0]) acc = acc - term;
        else acc = acc + term;
        p = (p >> i) >> i;
        k = k + 1;
      end
      arctan_q60[i] = acc;
    end
    rotate_vec(ONE_Q60, '0, x, y);
    an = isqrt128(mul128(abs64(x), abs64(x)) + mul128(abs64(y), abs64(y)));
    rem = ONE_Q60;
    q = '0;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= an) begin
        rem = rem - an;
        q = q | 64'd1;
      end
    end
    inv_gain_q60 = q;
  endtask

  // angle units to Q60 radians; sh = 32 for half angles, 31 for full
  function automatic logic signed [63:0] to_radians(input logic [63:0] m, input int sh);
    logic [63:0] hi_part, lo_part;
    hi_part = (m * (PI_Q60 >> 32)) << (32 - sh);
    lo_part = (m * (PI_Q60 & 64'hFFFF_FFFF)) >> sh;
    return hi_part + lo_part;
  endfunction

  task automatic sin_half_diff(input logic signed [31:0] p, input logic signed [31:0] q,
                               output logic [63:0] s);
    logic signed [31:0] d;
    logic signed [63:0] x, y;
    d = q - p; // wraps modulo a full turn
    rotate_vec(inv_gain_q60, to_radians(abs64(64'(d)), 32), x, y);
    s = abs64(y);
  endtask

  // cosine magnitude and sign; latitudes past the poles are reflected
  task automatic cos_latitude(input logic signed [31:0] lat_in, output logic [63:0] c,
                              output logic neg);
    logic signed [63:0] lat, x, y;
    lat = 64'(lat_in);
    neg = 1'b0;
    if (lat > (64'sd1 <<< 30)) begin
      lat = lat - (64'sd1 <<< 31); neg = 1'b1;
    end else if (lat < -(64'sd1 <<< 30)) begin
      lat = lat + (64'sd1 <<< 31); neg = 1'b1;
    end
    rotate_vec(inv_gain_q60, to_radians(abs64(lat), 31), x, y);
    if (x < 0) neg = ~neg;
    c = abs64(x);
  endtask

  task automatic predict_distance(input point_pair_t pp, input logic [23:0] rad,
                                  output logic [35:0] dist_mm);
    logic [63:0] s_lat, s_lon, c1, c2, cc, u, ang, d64;
    logic n1, n2;
    logic [127:0] hav, cross_term, comp, prod;
    logic signed [63:0] x, y, z, dx, dy;
    sin_half_diff(pp.lat1, pp.lat2, s_lat);
    sin_half_diff(pp.lon1, pp.lon2, s_lon);
    cos_latitude(pp.lat1, c1, n1);
    cos_latitude(pp.lat2, c2, n2);
    prod = mul128(c1, c2);
    cc = prod[123:60];
    prod = mul128(cc, s_lon);
    u = prod[123:60];
    cross_term = mul128(u, s_lon);
    hav = mul128(s_lat, s_lat);
    // clamp a to [0,1]; a negative cosine product subtracts
    if (n1 != n2) begin
      hav = (cross_term >= hav) ? '0 : hav - cross_term;
    end else begin
      hav = hav + cross_term;
      if (hav > ONE_Q120) hav = ONE_Q120;
    end
    comp = ONE_Q120 - hav;
    y = isqrt128(hav);
    x = isqrt128(comp);
    z = '0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + arctan_q60[i];
      end else begin
        x = x - dx; y = y + dy; z = z - arctan_q60[i];
      end
    end
    if (z < 0) z = '0;
    ang = 64'(z) * 2;
    prod = mul128(64'(rad) * 64'd1000, ang) + (128'd1 << 59);
    d64 = prod[123:60];
    if (d64 > 64'(DIST_MAX)) d64 = 64'(DIST_MAX);
    dist_mm = d64[35:0];
  endtask

  // ---------------------------------------------------------------------
  // Driver, monitor, watchdog
  // ---------------------------------------------------------------------
  point_pair_t pending_pairs[$];
  logic [35:0] expected_mm[$];
  int idle_pct = 0;
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int saturated_seen = 0;
  logic beat_taken = 1'b0;

  always @(negedge clk_i) begin
    point_pair_t pp;
    if (!rst_ni || (start && !beat_taken)) begin
      // hold the current beat
    end else if (pending_pairs.size() == 0 || $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
    end else begin
      pp = pending_pairs.pop_front();
      first_latitude_i <= pp.lat1;
      first_longitude_i <= pp.lon1;
      second_latitude_i <= pp.lat2;
      second_longitude_i <= pp.lon2;
      start <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    point_pair_t pp;
    logic [35:0] d;
    logic [35:0] want;
    beat_taken = rst_ni && start && !busy;
    if (beat_taken) begin
      pp = '{first_latitude_i, first_longitude_i, second_latitude_i, second_longitude_i};
      predict_distance(pp, radius_m, d);
      expected_mm.push_back(d);
      pairs_sent++;
    end
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_mm.size() == 0) begin
        $error("unexpected result beat: distance_mm=%0d", distance_mm_o);
        errors++;
      end else begin
        want = expected_mm.pop_front();
        if (want == DIST_MAX) saturated_seen++;
        if (distance_mm_o !== want) begin
          $error("distance_mm mismatch: expected %0d, actual %0d", want, distance_mm_o);
          errors++;
        end
      end
    end
    // watchdog: only counts while work is outstanding
    if (beat_taken || done_o || (pending_pairs.size() == 0 && expected_mm.size() == 0))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", stall_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic logic signed [31:0] rand_lat();
    return $signed($urandom_range(32'h8000_0000, 0)) - 32'sh4000_0000;
  endfunction

  function automatic logic signed [31:0] small_jitter();
    return $signed($urandom_range(2000, 0)) - 1000;
  endfunction

  // mostly uniform pairs; some near-antipodal (clamp/saturation) and near-identical
  function automatic point_pair_t rand_pair();
    point_pair_t pp;
    int kind;
    kind = $urandom_range(9);
    pp.lat1 = rand_lat();
    pp.lon1 = $urandom();
    if (kind < 6) begin
      pp.lat2 = rand_lat();
      pp.lon2 = $urandom();
    end else if (kind < 8) begin
      pp.lat2 = -pp.lat1 + small_jitter();
      if (pp.lat2 > LAT_N) pp.lat2 = LAT_N;
      if (pp.lat2 < LAT_S) pp.lat2 = LAT_S;
      pp.lon2 = pp.lon1 + 32'sh8000_0000 + small_jitter();
    end else begin
      pp.lat2 = pp.lat1 + small_jitter();
      if (pp.lat2 > LAT_N) pp.lat2 = LAT_N;
      if (pp.lat2 < LAT_S) pp.lat2 = LAT_S;
      pp.lon2 = pp.lon1 + small_jitter();
    end
    return pp;
  endfunction

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write the radius, then read it back
  task automatic set_radius(input logic [23:0] r);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_RADIUS, 32'(r), rd);
    radius_m = r;
    apb_access(1'b0, ADDR_RADIUS, '0, rd);
    if (rd[23:0] !== r) begin
      $error("earth_radius_m readback mismatch: expected %0d, actual %0d", r, rd[23:0]);
      errors++;
    end
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !start);
    wait (expected_mm.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
  endtask

  initial begin
    logic [31:0] rd;
    build_tables();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset value of the radius register
    apb_access(1'b0, ADDR_RADIUS, '0, rd);
    if (rd[23:0] !== RADIUS_RESET) begin
      $error("earth_radius_m reset mismatch: expected %0d, actual %0d",
             RADIUS_RESET, rd[23:0]);
      errors++;
    end

    // directed: same point, poles, antipodes, longitude wrap, field extremes
    idle_pct = 12;
    pending_pairs.push_back('{32'sd0, 32'sd0, 32'sd0, 32'sd0});
    pending_pairs.push_back('{LAT_N, 32'sd0, LAT_S, 32'sd0});
    pending_pairs.push_back('{LAT_N, LON_MIN, LAT_N, LON_MAX});
    pending_pairs.push_back('{LAT_S, 32'sd0, LAT_S, LON_MIN});
    pending_pairs.push_back('{32'sd0, 32'sd0, 32'sd0, LON_MIN});
    pending_pairs.push_back('{32'sd0, LON_MIN, 32'sd0, LON_MAX});
    pending_pairs.push_back('{32'sd0, LON_MAX, 32'sd0, LON_MIN});
    pending_pairs.push_back('{32'sd0, 32'sd0, 32'sd0, 32'sh4000_0000});
    pending_pairs.push_back('{32'sh2000_0000, 32'sd0, -32'sh2000_0000, LON_MIN});
    pending_pairs.push_back('{32'sh2000_0001, 32'sd5, -32'sh2000_0000, LON_MIN});
    pending_pairs.push_back('{LAT_N, 32'sd0, LAT_N, 32'sd12345});
    pending_pairs.push_back('{32'sd1, 32'sd0, 32'sd0, 32'sd0});
    pending_pairs.push_back('{32'sd0, 32'sd0, 32'sd0, 32'sd1});
    pending_pairs.push_back('{LAT_S, LON_MAX, LAT_N, LON_MIN});
    pending_pairs.push_back('{32'sh1555_5555, 32'shAAAA_AAAA, -32'sh2AAA_AAAA, 32'sh5555_5555});
    pending_pairs.push_back('{32'sh3FFF_FFFF, 32'sh7000_0000, -32'sh3FFF_FFFF, -32'sh1000_0000});
    queue_random(400);
    drain();

    // largest radius gives the longest arcs, close to the saturation limit
    set_radius(RADIUS_MAX);
    idle_pct = 85;
    pending_pairs.push_back('{LAT_N, 32'sd0, LAT_S, 32'sd0});
    pending_pairs.push_back('{32'sd0, 32'sd0, 32'sd0, LON_MIN});
    queue_random(400);
    drain();

    set_radius(RADIUS_MIN);
    idle_pct = 0;
    pending_pairs.push_back('{LAT_N, 32'sd0, LAT_S, 32'sd0});
    queue_random(200);
    drain();

    set_radius(24'($urandom_range(32'hFF_FFFF, 1)));
    queue_random(200);
    drain();

    $display("covered %0d point pairs, %0d results (%0d saturated), four radius settings",
             pairs_sent, results_seen, saturated_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
